// ===== design/smt_pkg.sv =====
// Shared types and constants for the sliding mode tracker.
package smt_pkg;

	localparam int VALUE_W      = 10;
	localparam int MODE_COUNT_W = 13;
	localparam int STATUS_W     = 2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

	typedef struct packed {
		logic               opcode;
		logic [VALUE_W-1:0] item_value;
	} in_item_t;

	typedef struct packed {
		logic [MODE_COUNT_W-1:0] mode_count;
		logic [VALUE_W-1:0]      mode_value;
		logic [STATUS_W-1:0]     status;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

// ===== design/smt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module smt_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/sliding_mode_tracker_top.sv =====
// Top level of the sliding mode tracker: running mode of a multiset of values.
//
// Input channel (in_valid, in_stall, in_data) carries one transaction per item: an opcode
// that inserts or removes one occurrence of item_value. Output channel (out_valid,
// out_stall, out_data) returns one transaction per item with the highest count, the
// largest value at that count and a status code.
// Items are handled one at a time. An ordinary item passes through the READ and DONE
// states from acceptance to its result being loaded into the output register, and the
// next item can be accepted once the block is back in IDLE after that load. An item
// whose value lies beyond the table skips the memory read and goes straight to DONE.
// Removing the current mode value starts a pass over the whole count memory in the SCAN
// state, one address per cycle through its read port.
// The output register decouples the two sides: the next item is accepted while the
// previous result still waits. If the receiver stalls, the finished result is held in
// the output register and a following result waits in the block until it is free.
// After reset the count memory is cleared one entry per cycle; in_stall stays high until
// that pass has finished.
module sliding_mode_tracker_top #(
	parameter int NUM_VALUES = 1024,
	parameter int MAX_COUNT  = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  smt_pkg::in_item_t  in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output smt_pkg::out_item_t out_data
);
	import smt_pkg::*;

	localparam int AW = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1;
	localparam int CW = $clog2(MAX_COUNT + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_VALUES - 1);
	localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_COUNT);

	state_t state_q, state_d;

	logic [AW-1:0]       addr_q;
	logic                issue_q;
	logic                scan_vld_s1;
	logic [AW-1:0]       scan_addr_s1;
	logic                op_q;
	logic [AW-1:0]       item_addr_q;
	logic [STATUS_W-1:0] status_q;
	logic [CW-1:0]       mode_cnt_q;
	logic [AW-1:0]       mode_val_q;
	logic                out_vld_q;
	out_item_t           out_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [CW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [CW-1:0] ram_rdata;

	logic          accept;
	logic          in_range;
	logic          ins_ok;
	logic          rem_ok;
	logic [CW-1:0] cnt_inc;
	logic [CW-1:0] cnt_dec;
	logic          ins_better;
	logic          hits_mode;
	logic          scan_done;
	logic          scan_better;
	logic          out_load;

	smt_ram #(
		.WIDTH(CW),
		.DEPTH(NUM_VALUES)
	) u_count_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign accept   = in_valid && !in_stall;
	assign in_range = ({22'd0, in_data.item_value} < 32'(NUM_VALUES));

	assign cnt_inc    = CW'(ram_rdata + 1'b1);
	assign cnt_dec    = CW'(ram_rdata - 1'b1);
	assign ins_ok     = (op_q == OP_INSERT) && (ram_rdata < MAX_CNT);
	assign rem_ok     = (op_q == OP_REMOVE) && (ram_rdata != '0);
	assign ins_better = (cnt_inc > mode_cnt_q) ||
	                    ((cnt_inc == mode_cnt_q) && (item_addr_q > mode_val_q));
	assign hits_mode  = (item_addr_q == mode_val_q) && (ram_rdata == mode_cnt_q);

	// Later addresses win ties, so the largest value at the top count survives the pass.
	assign scan_better = (ram_rdata != '0) && (ram_rdata >= mode_cnt_q);
	assign scan_done   = scan_vld_s1 && (scan_addr_s1 == LAST_ADDR);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (addr_q == LAST_ADDR) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = in_range ? ST_READ : ST_DONE;
			end
			ST_READ: begin
				state_d = (rem_ok && hits_mode) ? ST_SCAN : ST_DONE;
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Memory port and handshake controls.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = item_addr_q;
		ram_wdata = '0;
		ram_raddr = addr_q;
		in_stall  = 1'b1;
		out_load  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = addr_q;
			end
			ST_IDLE: begin
				in_stall  = 1'b0;
				ram_raddr = AW'(in_data.item_value);
			end
			ST_READ: begin
				ram_we    = ins_ok || rem_ok;
				ram_wdata = ins_ok ? cnt_inc : cnt_dec;
			end
			ST_SCAN: begin
				ram_raddr = addr_q;
			end
			ST_DONE: begin
				out_load = !out_vld_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			addr_q      <= '0;
			issue_q     <= 1'b0;
			scan_vld_s1 <= 1'b0;
			mode_cnt_q  <= '0;
			mode_val_q  <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			scan_vld_s1 <= (state_q == ST_SCAN) && issue_q;

			if (state_q == ST_CLEAR) begin
				addr_q <= (addr_q == LAST_ADDR) ? '0 : AW'(addr_q + 1'b1);
			end

			if (state_q == ST_READ) begin
				if (ins_ok && ins_better) begin
					mode_cnt_q <= cnt_inc;
					mode_val_q <= item_addr_q;
				end
				if (rem_ok && hits_mode) begin
					mode_cnt_q <= '0;
					mode_val_q <= '0;
					addr_q     <= '0;
					issue_q    <= 1'b1;
				end
			end

			if (state_q == ST_SCAN) begin
				if (issue_q) begin
					if (addr_q == LAST_ADDR) begin
						issue_q <= 1'b0;
					end else begin
						addr_q <= AW'(addr_q + 1'b1);
					end
				end
				if (scan_vld_s1 && scan_better) begin
					mode_cnt_q <= ram_rdata;
					mode_val_q <= scan_addr_s1;
				end
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		scan_addr_s1 <= addr_q;
		if (accept) begin
			op_q        <= in_data.opcode;
			item_addr_q <= AW'(in_data.item_value);
			status_q    <= in_range ? STATUS_OK :
			               ((in_data.opcode == OP_INSERT) ? STATUS_FULL : STATUS_ABSENT);
		end
		if (state_q == ST_READ) begin
			if (op_q == OP_INSERT && !ins_ok) status_q <= STATUS_FULL;
			if (op_q == OP_REMOVE && !rem_ok) status_q <= STATUS_ABSENT;
		end
		if (out_load) begin
			out_q.mode_count <= MODE_COUNT_W'(mode_cnt_q);
			out_q.mode_value <= VALUE_W'(mode_val_q);
			out_q.status     <= status_q;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

// ===== design/smt_checker.sv =====
// Port-level checker for the sliding mode tracker, bound to the top level.
module smt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input smt_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_stall,
	input smt_pkg::out_item_t out_data
);
	import smt_pkg::*;

	// A stalled result stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed or vanished while stalled");

	// One item at a time: the block is busy in the cycle after a transaction is accepted.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a previous item is still in work");

	// An empty multiset reports value zero.
	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.mode_count == '0) |-> (out_data.mode_value == '0))
		else $error("empty mode reported with a nonzero value");

	// Only defined status codes leave the block.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == STATUS_OK) || (out_data.status == STATUS_ABSENT) ||
		              (out_data.status == STATUS_FULL))
		else $error("undefined status code on the output");

endmodule

bind sliding_mode_tracker_top smt_checker u_smt_checker (.*);

// ===== sim/sliding_mode_tracker_top_test.sv =====
// Self-checking testbench for the sliding mode tracker, with its own running-mode predictor.
`timescale 1ns / 100ps

module sliding_mode_tracker_top_test;
	import smt_pkg::*;

	localparam int TABLE_SIZE    = 1024;
	localparam int FULL_COUNT    = 4096;
	localparam int RANDOM_ITEMS  = 580;
	localparam int SETTLE_CYCLES = 1200;
	localparam int REPORT_LIMIT  = 10;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;

	// Predictor state: occurrence count per value and the current mode.
	logic [MODE_COUNT_W-1:0] tally [TABLE_SIZE];
	logic [MODE_COUNT_W-1:0] top_count;
	logic [VALUE_W-1:0]      top_value;
	out_item_t               pending_modes [$];

	int fail_count  = 0;
	int burst_left  = 0;
	int stall_left  = 0;
	int rx_tick     = 0;
	bit rx_calm     = 1'b0;

	sliding_mode_tracker_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #10 clk = ~clk;

	function automatic out_item_t next_mode(input in_item_t it);
		out_item_t               r;
		logic [MODE_COUNT_W-1:0] c;
		logic [MODE_COUNT_W-1:0] best_count;
		logic [VALUE_W-1:0]      best_value;
		r.status = STATUS_OK;
		if (int'(it.item_value) >= TABLE_SIZE) begin
			r.status = (it.opcode == OP_INSERT) ? STATUS_FULL : STATUS_ABSENT;
		end else if (it.opcode == OP_INSERT) begin
			c = tally[it.item_value];
			if (c >= FULL_COUNT) begin
				r.status = STATUS_FULL;
			end else begin
				c = c + 1'b1;
				tally[it.item_value] = c;
				if (c > top_count || (c == top_count && it.item_value > top_value)) begin
					top_count = c;
					top_value = it.item_value;
				end
			end
		end else begin
			c = tally[it.item_value];
			if (c == 0) begin
				r.status = STATUS_ABSENT;
			end else begin
				tally[it.item_value] = c - 1'b1;
				// Losing an occurrence of the mode means the whole table must be searched again.
				if (it.item_value == top_value && c == top_count) begin
					best_count = '0;
					best_value = '0;
					for (int v = 0; v < TABLE_SIZE; v++) begin
						if (tally[v] != 0 && tally[v] >= best_count) begin
							best_count = tally[v];
							best_value = VALUE_W'(v);
						end
					end
					top_count = best_count;
					top_value = best_value;
				end
			end
		end
		r.mode_count = top_count;
		r.mode_value = top_value;
		return r;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%s", msg);
	endtask

	// Sender pacing: bursts of random length separated by random gaps.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
		gap = $urandom_range(1, 12);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (gap - 1) @(negedge clk);
	endtask

	task automatic send_item(input logic op, input logic [VALUE_W-1:0] v);
		in_item_t it;
		it.opcode     = op;
		it.item_value = v;
		@(negedge clk);
		in_data  <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_modes.push_back(next_mode(it));
		pace_sender();
	endtask

	task automatic test_empty_removes();
		send_item(OP_REMOVE, 10'd0);
		send_item(OP_REMOVE, 10'd1023);
	endtask

	// Ties, mode hand-over on removal, a lone value 0 as mode and the return to empty.
	task automatic test_tie_breaks();
		send_item(OP_INSERT, 10'd5);
		send_item(OP_INSERT, 10'd3);
		send_item(OP_INSERT, 10'd3);
		send_item(OP_INSERT, 10'd1023);
		send_item(OP_INSERT, 10'd1023);
		send_item(OP_INSERT, 10'd0);
		send_item(OP_REMOVE, 10'd1023);
		send_item(OP_REMOVE, 10'd3);
		send_item(OP_REMOVE, 10'd5);
		send_item(OP_REMOVE, 10'd5);
		send_item(OP_INSERT, 10'd341);
		send_item(OP_INSERT, 10'd682);
		send_item(OP_INSERT, 10'd682);
		send_item(OP_REMOVE, 10'd682);
		send_item(OP_REMOVE, 10'd1023);
		send_item(OP_REMOVE, 10'd682);
		send_item(OP_REMOVE, 10'd341);
		send_item(OP_REMOVE, 10'd3);
		send_item(OP_REMOVE, 10'd0);
	endtask

	// A sliding window over a small pool of values, with some stray inserts and removes.
	task automatic test_random_window();
		logic [VALUE_W-1:0] pool [$];
		logic [VALUE_W-1:0] window [$];
		logic [VALUE_W-1:0] v;
		int                 target_size;
		int                 idx;
		bit                 removing;
		target_size = 8;
		for (int sent = 0; sent < RANDOM_ITEMS; sent++) begin
			if (sent % 80 == 0) begin
				pool.delete();
				repeat ($urandom_range(2, 12))
					pool.push_back(VALUE_W'($urandom_range(0, TABLE_SIZE - 1)));
				target_size = $urandom_range(4, 40);
			end
			if ($urandom_range(0, 99) < 12) begin
				v        = VALUE_W'($urandom_range(0, TABLE_SIZE - 1));
				removing = 1'($urandom_range(0, 1));
			end else if (window.size() == 0) begin
				v        = pool[$urandom_range(0, pool.size() - 1)];
				removing = 1'b0;
			end else begin
				removing = (window.size() < target_size) ? ($urandom_range(0, 99) < 35)
				                                         : ($urandom_range(0, 99) < 65);
				if (!removing)
					v = pool[$urandom_range(0, pool.size() - 1)];
				else if ($urandom_range(0, 2) == 0 && tally[top_value] != 0)
					v = top_value;
				else
					v = window[$urandom_range(0, window.size() - 1)];
			end
			if (removing) begin
				for (idx = 0; idx < window.size(); idx++) begin
					if (window[idx] == v) begin
						window.delete(idx);
						break;
					end
				end
				send_item(OP_REMOVE, v);
			end else begin
				window.push_back(v);
				send_item(OP_INSERT, v);
			end
		end
	endtask

	task automatic finish_traffic();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_modes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver stall pattern: short random stalls, with calm stretches now and then.
	always @(negedge clk) begin
		rx_tick++;
		if (rx_tick % 300 == 0)
			rx_calm = ($urandom_range(0, 2) == 0);
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(0, 6);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_modes.size() == 0) begin
				note_failure($sformatf("unexpected transaction: count %0d value %0d status %0d",
					out_data.mode_count, out_data.mode_value, out_data.status));
			end else begin
				want = pending_modes.pop_front();
				if (out_data.mode_count !== want.mode_count ||
				    out_data.mode_value !== want.mode_value ||
				    out_data.status !== want.status)
					note_failure($sformatf(
						"mismatch: expected count %0d value %0d status %0d, got %0d %0d %0d",
						want.mode_count, want.mode_value, want.status,
						out_data.mode_count, out_data.mode_value, out_data.status));
			end
		end
	end

	initial begin
		#60_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		for (int v = 0; v < TABLE_SIZE; v++)
			tally[v] = '0;
		top_count = '0;
		top_value = '0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_removes();
		test_tie_breaks();
		test_random_window();
		finish_traffic();

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
